[src/rse_pkg.sv]
// Shared types, codes and widths of the postfix stack evaluator.
package rse_pkg;
    localparam int unsigned StackDepth = 32;
    localparam int unsigned AddrW = $clog2(StackDepth);
    localparam int unsigned DepthW = 6;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_MUL = 3'd1;
    localparam logic [2:0] OP_DIV = 3'd2;
    localparam logic [2:0] OP_GCD = 3'd3;
    localparam logic [2:0] OP_LCM = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DIVZERO  = 2'd1;
    localparam logic [1:0] ERR_FEWOPS   = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } t_div_rsp;
endpackage

[src/rse_ram.sv]
// Operand stack memory: one write port, one registered read port.
module rse_ram #(
    parameter int unsigned ADDR_W = 5,
    parameter int unsigned DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/rse_div.sv]
// Signed truncating divider, one quotient bit per cycle.
module rse_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rse_pkg::t_div_req i_req,
    output rse_pkg::t_div_rsp o_rsp
);
    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_quo, r_rem, r_dvs;
    logic        r_negq, r_negr;
    logic [32:0] w_trial;
    logic [31:0] w_rem_sh;
    logic [31:0] w_a_abs, w_b_abs;

    assign w_a_abs = i_req.dividend[31] ? 32'(-i_req.dividend) : i_req.dividend;
    assign w_b_abs = i_req.divisor[31] ? 32'(-i_req.divisor) : i_req.divisor;
    assign w_rem_sh = {r_rem[30:0], r_quo[31]};
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 6'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= w_a_abs;
                r_rem  <= '0;
                r_dvs  <= w_b_abs;
                r_negq <= i_req.dividend[31] ^ i_req.divisor[31];
                r_negr <= i_req.dividend[31];
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_negq ? 32'(-r_quo) : r_quo;
    assign o_rsp.remainder = r_negr ? 32'(-r_rem) : r_rem;
endmodule

[src/rpn_stack_evaluator.sv]
// Top level of the postfix stack evaluator.
// One token at a time: the next request is taken only after the result has been accepted.
// Push, clear and ignored tokens go straight to the top-of-stack read; add and multiply read
// two operands, compute and write back; divide runs the bit-serial divider first. Gcd runs one
// division per Euclid step (at most about 45 steps) and lcm adds one more division. Operands
// are read from the stack memory one entry per cycle, the result is written back before the
// next token, and a result waits for m_axis_tready while the input stays stalled.
module rpn_stack_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // value[31:0], opcode[34:32], zero fill
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // top_value[31:0], depth[37:32], zero fill
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD1 = 4'd1, S_RD2 = 4'd2, S_OPR = 4'd3,
                           S_DIV = 4'd4, S_GCD = 4'd5, S_LCMD = 4'd6, S_WB = 4'd7,
                           S_TOP = 4'd8, S_TOPW = 4'd9, S_OUT = 4'd10, S_EXE = 4'd11,
                           S_TOPD = 4'd12;

    logic [3:0]  r_st;
    logic [rse_pkg::DepthW-1:0] r_sp;
    logic [1:0]  r_err;
    logic [2:0]  r_op;
    logic [31:0] r_l, r_r, r_res, r_b, r_top;
    logic        r_we;
    logic [rse_pkg::AddrW-1:0] r_waddr;
    logic [31:0] r_wdata;
    logic [rse_pkg::AddrW-1:0] r_raddr;
    logic [31:0] w_rdata;
    rse_pkg::t_div_req w_dreq;
    rse_pkg::t_div_rsp w_drsp;
    logic [1:0]  w_kind;
    logic [2:0]  w_opc;
    logic [rse_pkg::DepthW-1:0] w_sp_m1, w_sp_m2;
    logic        w_push_ok;

    assign w_kind = s_axis_tuser;
    assign w_opc  = s_axis_tdata[34:32];
    assign w_sp_m1 = r_sp - 6'd1;
    assign w_sp_m2 = r_sp - 6'd2;
    assign w_push_ok = (r_st == S_IDLE) && s_axis_tvalid && (w_kind == rse_pkg::KIND_PUSH)
                       && (r_err == rse_pkg::ERR_NONE) && (r_sp < 6'(rse_pkg::StackDepth));

    rse_ram #(.ADDR_W(rse_pkg::AddrW), .DATA_W(32)) u_ram (
        .i_clk(i_clk), .i_we(r_we), .i_waddr(r_waddr), .i_wdata(r_wdata),
        .i_raddr(r_raddr), .o_rdata(w_rdata)
    );

    rse_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = {2'b0, r_sp, r_top};
    assign m_axis_tuser  = r_err;

    always_comb begin
        w_dreq = '0;
        if (r_st == S_EXE && (r_op == rse_pkg::OP_DIV) && r_r != 32'd0) begin
            w_dreq.start = 1'b1; w_dreq.dividend = r_l; w_dreq.divisor = r_r;
        end else if (r_st == S_EXE && (r_op == rse_pkg::OP_GCD || r_op == rse_pkg::OP_LCM)
                     && r_l != 32'd0 && r_r != 32'd0) begin
            w_dreq.start = 1'b1; w_dreq.dividend = r_l; w_dreq.divisor = r_r;
        end else if (r_st == S_GCD && w_drsp.done && w_drsp.remainder != 32'd0) begin
            w_dreq.start = 1'b1; w_dreq.dividend = r_b; w_dreq.divisor = w_drsp.remainder;
        end else if (r_st == S_GCD && w_drsp.done && r_op == rse_pkg::OP_LCM) begin
            w_dreq.start = 1'b1; w_dreq.dividend = 32'(r_l * r_r); w_dreq.divisor = r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_sp  <= '0;
            r_err <= rse_pkg::ERR_NONE;
            r_we  <= 1'b0;
        end else begin
            r_we <= w_push_ok || (r_st == S_WB);
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    if (w_kind == rse_pkg::KIND_CLEAR) begin
                        r_sp  <= '0;
                        r_err <= rse_pkg::ERR_NONE;
                        r_st  <= S_TOP;
                    end else if (r_err == rse_pkg::ERR_NONE && w_kind == rse_pkg::KIND_PUSH) begin
                        r_st <= S_TOP;
                        if (r_sp >= 6'(rse_pkg::StackDepth)) begin
                            r_err <= rse_pkg::ERR_OVERFLOW;
                        end else begin
                            r_waddr <= r_sp[rse_pkg::AddrW-1:0];
                            r_wdata <= s_axis_tdata[31:0];
                            r_sp    <= r_sp + 6'd1;
                        end
                    end else if (r_err == rse_pkg::ERR_NONE && w_kind == rse_pkg::KIND_OP
                                 && w_opc <= rse_pkg::OP_LCM) begin
                        if (r_sp < 6'd2) begin
                            r_err <= rse_pkg::ERR_FEWOPS;
                            r_st  <= S_TOP;
                        end else begin
                            r_op    <= w_opc;
                            r_raddr <= w_sp_m1[rse_pkg::AddrW-1:0];
                            r_st    <= S_RD1;
                        end
                    end else begin
                        r_st <= S_TOP;
                    end
                end
                S_RD1: begin
                    r_raddr <= w_sp_m2[rse_pkg::AddrW-1:0];
                    r_st    <= S_RD2;
                end
                S_RD2: begin
                    r_r  <= w_rdata;
                    r_st <= S_OPR;
                end
                S_OPR: begin
                    r_l  <= w_rdata;
                    r_st <= S_EXE;
                end
                S_EXE: begin
                    unique case (r_op) inside
                        rse_pkg::OP_ADD: begin
                            r_res <= r_l + r_r;
                            r_st  <= S_WB;
                        end
                        rse_pkg::OP_MUL: begin
                            r_res <= 32'(r_l * r_r);
                            r_st  <= S_WB;
                        end
                        rse_pkg::OP_DIV: begin
                            if (r_r == 32'd0) begin
                                r_err <= rse_pkg::ERR_DIVZERO;
                                r_st  <= S_TOP;
                            end else r_st <= S_DIV;
                        end
                        rse_pkg::OP_GCD, rse_pkg::OP_LCM: begin
                            if (r_l == 32'd0 || r_r == 32'd0) begin
                                r_res <= (r_op == rse_pkg::OP_LCM) ?
                                         32'd0 : ((r_l == 32'd0) ? r_r : r_l);
                                r_st  <= S_WB;
                            end else begin
                                r_b  <= r_r;
                                r_st <= S_GCD;
                            end
                        end
                        default: r_st <= S_TOP;
                    endcase
                end
                S_DIV: if (w_drsp.done) begin
                    r_res <= w_drsp.quotient;
                    r_st  <= S_WB;
                end
                S_GCD: if (w_drsp.done) begin
                    if (w_drsp.remainder != 32'd0) begin
                        r_b <= w_drsp.remainder;
                    end else if (r_op == rse_pkg::OP_LCM) begin
                        r_st <= S_LCMD;
                    end else begin
                        r_res <= r_b;
                        r_st  <= S_WB;
                    end
                end
                S_LCMD: if (w_drsp.done) begin
                    r_res <= w_drsp.quotient;
                    r_st  <= S_WB;
                end
                S_WB: begin
                    r_waddr <= w_sp_m2[rse_pkg::AddrW-1:0];
                    r_wdata <= r_res;
                    r_sp    <= r_sp - 6'd1;
                    r_st    <= S_TOP;
                end
                S_TOP: begin
                    r_raddr <= w_sp_m1[rse_pkg::AddrW-1:0];
                    r_st    <= S_TOPD;
                end
                S_TOPD: r_st <= S_TOPW;
                S_TOPW: r_st <= S_OUT;
                S_OUT: if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_TOPW) begin
            r_top <= (r_sp == 6'd0) ? 32'd0 : w_rdata;
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= 6'(rse_pkg::StackDepth)) else $error("depth above capacity");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
    a_wb_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WB) |=> (r_sp == $past(r_sp) - 6'd1)) else $error("pop lost");
    a_err_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE && r_err != rse_pkg::ERR_NONE && !(s_axis_tvalid
         && s_axis_tuser == rse_pkg::KIND_CLEAR)) |=> $stable(r_sp))
        else $error("stack moved under error");
    a_div_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dreq.start |-> (w_dreq.divisor != 32'd0)) else $error("zero divisor");
`endif
endmodule

[tb/rpn_stack_evaluator_tb.sv]
// Self-checking testbench of the postfix stack evaluator: directed table, overflow fill, then random tokens.
module rpn_stack_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] top;
        logic [5:0]  depth;
    } t_answer;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [2:0]  opcode;
        logic        typed;
        t_answer     answer;
    } t_row;

    localparam int unsigned LIMIT = 10000000;
    localparam logic [1:0] KIND_NONE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    rpn_stack_evaluator dut (.*);

    logic [31:0] calc_stack [rse_pkg::StackDepth];
    int unsigned calc_sp;
    logic [1:0]  calc_err;
    t_answer     answers [$];
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned send_idle;
    int unsigned recv_idle;
    t_row        table_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] quot_of(logic [31:0] a, logic [31:0] b);
        if (b == 32'hFFFF_FFFF) return 32'd0 - a;
        return $signed(a) / $signed(b);
    endfunction

    function automatic logic [31:0] rem_of(logic [31:0] a, logic [31:0] b);
        if (b == 32'hFFFF_FFFF) return 32'd0;
        return $signed(a) % $signed(b);
    endfunction

    function automatic logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        if (a == 0) return b;
        if (b == 0) return a;
        while (b != 0) begin
            r = rem_of(a, b);
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_answer evaluate(logic [1:0] kind, logic [31:0] value, logic [2:0] opc);
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] res;
        logic [31:0] g;
        t_answer     a;
        if (kind == rse_pkg::KIND_CLEAR) begin
            calc_sp = 0;
            calc_err = rse_pkg::ERR_NONE;
        end else if (calc_err == rse_pkg::ERR_NONE && kind == rse_pkg::KIND_PUSH) begin
            if (calc_sp >= rse_pkg::StackDepth) begin
                calc_err = rse_pkg::ERR_OVERFLOW;
            end else begin
                calc_stack[calc_sp] = value;
                calc_sp++;
            end
        end else if (calc_err == rse_pkg::ERR_NONE && kind == rse_pkg::KIND_OP
                     && opc <= rse_pkg::OP_LCM) begin
            if (calc_sp < 2) begin
                calc_err = rse_pkg::ERR_FEWOPS;
            end else begin
                r = calc_stack[calc_sp-1];
                l = calc_stack[calc_sp-2];
                res = 0;
                case (opc)
                    rse_pkg::OP_ADD: res = l + r;
                    rse_pkg::OP_MUL: res = l * r;
                    rse_pkg::OP_DIV: begin
                        if (r == 0) calc_err = rse_pkg::ERR_DIVZERO;
                        else res = quot_of(l, r);
                    end
                    rse_pkg::OP_GCD: res = gcd_of(l, r);
                    default: begin
                        g = gcd_of(l, r);
                        res = (g == 0) ? 32'd0 : quot_of(l * r, g);
                    end
                endcase
                if (calc_err == rse_pkg::ERR_NONE) begin
                    calc_sp--;
                    calc_stack[calc_sp-1] = res;
                end
            end
        end
        a.status = calc_err;
        a.top = calc_sp > 0 ? calc_stack[calc_sp-1] : 32'd0;
        a.depth = calc_sp[5:0];
        return a;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // Result side: random stall, compare each accepted result
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (answers.size() == 0) begin
                    report("unexpected result", m_axis_tdata[31:0], 32'd0);
                end else begin
                    want = answers.pop_front();
                    if (m_axis_tuser != want.status)
                        report("status", 32'(m_axis_tuser), 32'(want.status));
                    if (m_axis_tdata[31:0] != want.top) report("top", m_axis_tdata[31:0], want.top);
                    if (m_axis_tdata[37:32] != want.depth)
                        report("depth", 32'(m_axis_tdata[37:32]), 32'(want.depth));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(logic [1:0] kind, logic [31:0] value, logic [2:0] opc,
                        logic typed, t_answer answer);
        t_answer pred;
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {5'd0, opc, value};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        pred = evaluate(kind, value, opc);
        answers.push_back(pred);
        if (typed) begin
            if (pred.status != answer.status)
                report("table status", 32'(pred.status), 32'(answer.status));
            if (pred.top != answer.top) report("table top", pred.top, answer.top);
            if (pred.depth != answer.depth)
                report("table depth", 32'(pred.depth), 32'(answer.depth));
        end
    endtask

    function automatic void row(logic [1:0] k, logic [31:0] v, logic [2:0] o,
                                logic typed = 1'b0, logic [1:0] st = 2'd0,
                                logic [31:0] top = 32'd0, logic [5:0] d = 6'd0);
        t_row x;
        x.kind = k; x.value = v; x.opcode = o; x.typed = typed;
        x.answer = '{st, top, d};
        table_rows.push_back(x);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom_range(20);
            1: return -$urandom_range(20);
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(5000) * $urandom_range(1, 12);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int unsigned n);
        logic [1:0] k;
        int unsigned c;
        logic [2:0] o;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(99);
            if (c < 4) k = rse_pkg::KIND_CLEAR;
            else if (c < 6) k = KIND_NONE;
            else if (c < 50)
                k = (calc_sp < 2 && calc_err == rse_pkg::ERR_NONE) ?
                    rse_pkg::KIND_PUSH : rse_pkg::KIND_OP;
            else k = rse_pkg::KIND_PUSH;
            if (calc_err != rse_pkg::ERR_NONE && $urandom_range(3) == 0) k = rse_pkg::KIND_CLEAR;
            o = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
            send(k, rand_value(), o, 1'b0, '0);
        end
    endtask

    initial begin
        t_answer full_ans;
        cycles = 0;
        mismatches = 0;
        calc_sp = 0;
        calc_err = rse_pkg::ERR_NONE;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = rse_pkg::KIND_PUSH;
        m_axis_tready = 1'b0;
        send_idle = 25;
        recv_idle = 46;
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_ADD, 1'b1, rse_pkg::ERR_FEWOPS, 32'd0, 6'd0);
        row(rse_pkg::KIND_PUSH, 5, rse_pkg::OP_ADD, 1'b1, rse_pkg::ERR_FEWOPS, 32'd0, 6'd0);
        row(rse_pkg::KIND_CLEAR, 0, rse_pkg::OP_ADD, 1'b1, rse_pkg::ERR_NONE, 32'd0, 6'd0);
        row(rse_pkg::KIND_PUSH, 32'h8000_0000, rse_pkg::OP_ADD, 1'b1, rse_pkg::ERR_NONE,
            32'h8000_0000, 6'd1);
        row(rse_pkg::KIND_PUSH, 32'hFFFF_FFFF, rse_pkg::OP_ADD, 1'b1, rse_pkg::ERR_NONE,
            32'hFFFF_FFFF, 6'd2);
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_DIV, 1'b1, rse_pkg::ERR_NONE, 32'h8000_0000, 6'd1);
        row(rse_pkg::KIND_PUSH, 32'h7FFF_FFFF, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_PUSH, 12, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_MUL);
        row(rse_pkg::KIND_PUSH, 0, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_OP, 0, 3'd7);
        row(KIND_NONE, 0, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_GCD);
        row(rse_pkg::KIND_PUSH, 0, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_PUSH, 0, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_LCM);
        row(rse_pkg::KIND_PUSH, -18, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_PUSH, 12, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_LCM);
        row(rse_pkg::KIND_PUSH, 0, rse_pkg::OP_ADD);
        row(rse_pkg::KIND_OP, 0, rse_pkg::OP_DIV, 1'b1, rse_pkg::ERR_DIVZERO, 32'd0, 6'd4);
        row(rse_pkg::KIND_CLEAR, 0, rse_pkg::OP_ADD, 1'b1, rse_pkg::ERR_NONE, 32'd0, 6'd0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (table_rows[i])
            send(table_rows[i].kind, table_rows[i].value, table_rows[i].opcode,
                 table_rows[i].typed, table_rows[i].answer);
        // fill to capacity, then push once more to overflow
        for (int i = 0; i < rse_pkg::StackDepth; i++)
            send(rse_pkg::KIND_PUSH, $urandom, rse_pkg::OP_ADD, 1'b0, '0);
        full_ans.status = rse_pkg::ERR_OVERFLOW;
        full_ans.top = calc_stack[rse_pkg::StackDepth-1];
        full_ans.depth = 6'(rse_pkg::StackDepth);
        send(rse_pkg::KIND_PUSH, 32'd1, rse_pkg::OP_ADD, 1'b1, full_ans);
        send(rse_pkg::KIND_CLEAR, 32'd0, rse_pkg::OP_ADD, 1'b1, '0);
        random_phase(330);
        while (answers.size() != 0) @(posedge i_clk);
        send_idle = 46;
        recv_idle = 25;
        random_phase(330);
        send_idle = 0;
        recv_idle = 0;
        random_phase(340);
        while (answers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
